FILE: hw/rtl/grdfs_pkg.sv
// Shared types, codes and microcode for the graph reachability engine.
package grdfs_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int NODE_W = 6;
  localparam int CMD_W = 2;
  localparam int CNT_W = 7;
  localparam int STEP_W = 4;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_CLEAR = 4'd1;
  localparam step_t ST_EDGE_RD = 4'd2;
  localparam step_t ST_EDGE_WR = 4'd3;
  localparam step_t ST_ERR = 4'd4;
  localparam step_t ST_INIT = 4'd5;
  localparam step_t ST_EVAL = 4'd6;
  localparam step_t ST_POP = 4'd7;
  localparam step_t ST_DONE = 4'd8;

  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_DISPATCH = 2'd1,
    COND_SEARCH = 2'd2
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    cond_t cond;
    step_t jmp;
    step_t alt;
    step_t nxt;
    logic latch;
    logic clr_rows;
    logic edge_rd;
    logic edge_wr;
    logic srch_init;
    logic srch_eval;
    logic pop_load;
    logic emit_err;
    logic emit_hit;
  } ctl_t;

  // Flags that the datapath returns to the sequencer.
  typedef struct packed {
    logic in_ok;
    logic cand_any;
    logic last;
  } sts_t;

  function automatic ctl_t ucode(input step_t step);
    ctl_t w;
    w = '0;
    w.cond = COND_ALWAYS;
    w.jmp = ST_IDLE;
    w.alt = ST_IDLE;
    w.nxt = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        w.cond = COND_DISPATCH;
        w.latch = 1'b1;
      end
      ST_CLEAR: w.clr_rows = 1'b1;
      ST_EDGE_RD: begin
        w.edge_rd = 1'b1;
        w.nxt = ST_EDGE_WR;
      end
      ST_EDGE_WR: w.edge_wr = 1'b1;
      ST_ERR: w.emit_err = 1'b1;
      ST_INIT: begin
        w.srch_init = 1'b1;
        w.nxt = ST_EVAL;
      end
      ST_EVAL: begin
        w.cond = COND_SEARCH;
        w.srch_eval = 1'b1;
        w.jmp = ST_EVAL;
        w.alt = ST_DONE;
        w.nxt = ST_POP;
      end
      ST_POP: begin
        w.pop_load = 1'b1;
        w.nxt = ST_EVAL;
      end
      ST_DONE: w.emit_hit = 1'b1;
      default: w.nxt = ST_IDLE;
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input logic [CMD_W-1:0] cmd, input logic ok);
    step_t s;
    s = ST_IDLE;
    unique case (cmd)
      CMD_CLEAR: s = ST_CLEAR;
      CMD_EDGE: s = ok ? ST_EDGE_RD : ST_ERR;
      CMD_QUERY: s = ok ? ST_INIT : ST_ERR;
      default: s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/grdfs_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module grdfs_seq (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [grdfs_pkg::CMD_W-1:0] cmd,
  input  grdfs_pkg::sts_t sts,
  output grdfs_pkg::ctl_t ctl,
  output logic busy
);

  grdfs_pkg::step_t step;
  grdfs_pkg::step_t step_next;

  always_comb begin
    ctl = grdfs_pkg::ucode(step);
    unique case (ctl.cond)
      grdfs_pkg::COND_ALWAYS: step_next = ctl.nxt;
      grdfs_pkg::COND_DISPATCH: begin
        step_next = start ? grdfs_pkg::dispatch(cmd, sts.in_ok) : ctl.nxt;
      end
      grdfs_pkg::COND_SEARCH: begin
        priority if (sts.cand_any) step_next = ctl.jmp;
        else if (sts.last) step_next = ctl.alt;
        else step_next = ctl.nxt;
      end
      default: step_next = grdfs_pkg::ST_IDLE;
    endcase
  end

  assign busy = (step != grdfs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= grdfs_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: hw/rtl/grdfs_dp.sv
// Datapath: adjacency memory, walk stack, visited marks and result register.
module grdfs_dp #(
  parameter int MAX_NODES = grdfs_pkg::MAX_NODES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  grdfs_pkg::ctl_t ctl,
  output grdfs_pkg::sts_t sts,
  input  logic [grdfs_pkg::NODE_W-1:0] node_a,
  input  logic [grdfs_pkg::NODE_W-1:0] node_b,
  input  logic cfg_we,
  input  logic [grdfs_pkg::CNT_W-1:0] cfg_wdata,
  output logic done,
  output logic reachable,
  output logic status
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DW = $clog2(MAX_NODES + 1);
  localparam logic [grdfs_pkg::CNT_W-1:0] MaxCnt = grdfs_pkg::CNT_W'(MAX_NODES);

  logic [grdfs_pkg::NODE_W-1:0] a_q;
  logic [grdfs_pkg::NODE_W-1:0] b_q;
  logic [IW-1:0] a_idx;
  logic [IW-1:0] b_idx;

  logic [MAX_NODES-1:0] in_mask;
  logic [MAX_NODES-1:0] mask_next;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] row_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] row_q;
  logic rowv_q;
  logic [MAX_NODES-1:0] row_eff;
  logic [MAX_NODES-1:0] cand;
  logic [MAX_NODES-1:0] iso;
  logic [IW-1:0] nx;

  logic [IW-1:0] stk_mem [MAX_NODES];
  logic [IW-1:0] stk_q;
  logic [IW-1:0] pop_addr;
  logic [DW-1:0] depth;
  logic push_ok;

  logic [IW-1:0] rd_addr;
  logic rd_en;
  logic in_ok;

  assign a_idx = a_q[IW-1:0];
  assign b_idx = b_q[IW-1:0];

  // A node number is in range when it is below both the build size and the node count.
  assign in_ok = ({1'b0, node_a} < MaxCnt) && ({1'b0, node_b} < MaxCnt)
                 && in_mask[node_a[IW-1:0]] && in_mask[node_b[IW-1:0]];

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      mask_next[i] = (grdfs_pkg::CNT_W'(i) < cfg_wdata);
    end
  end

  // A row that has not been written since the last clear reads as empty.
  assign row_eff = rowv_q ? row_q : '0;
  assign cand = row_eff & in_mask & ~visited;
  assign iso = cand & (~cand + MAX_NODES'(1));

  always_comb begin
    nx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cand[i]) nx = IW'(i);
    end
  end

  assign push_ok = (depth < DW'(MAX_NODES));
  assign pop_addr = IW'(depth - DW'(2));

  always_comb begin
    priority if (ctl.edge_rd || ctl.srch_init) rd_addr = a_idx;
    else if (ctl.srch_eval) rd_addr = nx;
    else rd_addr = stk_q;
  end
  assign rd_en = ctl.edge_rd || ctl.srch_init || ctl.pop_load
                 || (ctl.srch_eval && (cand != '0));

  assign sts.in_ok = in_ok;
  assign sts.cand_any = (cand != '0);
  assign sts.last = (depth == DW'(1));

  always_ff @(posedge clk) begin
    if (ctl.edge_wr) row_mem[a_idx] <= row_eff | (MAX_NODES'(1) << b_idx);
    if (rd_en) row_q <= row_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.srch_init) begin
      stk_mem[0] <= a_idx;
    end else if (ctl.srch_eval && (cand != '0) && push_ok) begin
      stk_mem[depth[IW-1:0]] <= nx;
    end
    if (ctl.srch_eval && (cand == '0)) stk_q <= stk_mem[pop_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      a_q <= node_a;
      b_q <= node_b;
    end
    if (ctl.srch_init) begin
      visited <= MAX_NODES'(1) << a_idx;
      depth <= DW'(1);
    end else if (ctl.srch_eval) begin
      if (cand != '0) begin
        visited <= visited | iso;
        if (push_ok) depth <= depth + DW'(1);
      end else begin
        depth <= depth - DW'(1);
      end
    end
    reachable <= ctl.emit_hit ? visited[b_idx] : 1'b0;
    status <= ctl.emit_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rowv_q <= 1'b0;
      in_mask <= '1;
      done <= 1'b0;
    end else begin
      if (cfg_we) in_mask <= mask_next;
      if (ctl.clr_rows) begin
        row_valid <= '0;
      end else if (ctl.edge_wr) begin
        row_valid[a_idx] <= 1'b1;
      end
      if (rd_en) rowv_q <= row_valid[rd_addr];
      done <= ctl.emit_err || ctl.emit_hit;
    end
  end

endmodule

FILE: hw/rtl/graph_reachability_dfs.sv
// Top level of the graph reachability engine: sequencer and datapath.
//
//   channel   handshake          payload
//   command   start / busy       cmd, node_a, node_b
//   result    done (one cycle)   reachable, status
//   config    cfg_we             cfg_wdata (node count)
//
// Each command runs as a microprogram; a query walks depth first, pushing and
// popping a stack, paced by registered adjacency and stack reads. The result
// beat comes the cycle after the last step, with busy already low.
// Synchronous reset empties the graph at once through per-row valid bits and
// restores the full node count. The receiver cannot stall.
module graph_reachability_dfs #(
  parameter int MAX_NODES = grdfs_pkg::MAX_NODES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [grdfs_pkg::CMD_W-1:0] cmd,
  input  logic [grdfs_pkg::NODE_W-1:0] node_a,
  input  logic [grdfs_pkg::NODE_W-1:0] node_b,
  input  logic cfg_we,
  input  logic [grdfs_pkg::CNT_W-1:0] cfg_wdata,
  output logic done,
  output logic reachable,
  output logic status
);

  grdfs_pkg::ctl_t ctl;
  grdfs_pkg::sts_t sts;

  grdfs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy)
  );

  grdfs_dp #(
    .MAX_NODES(MAX_NODES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .node_a   (node_a),
    .node_b   (node_b),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .reachable(reachable),
    .status   (status)
  );

endmodule

FILE: hw/rtl/grdfs_chk.sv
// Port-level checker for the graph reachability engine, bound to the top level.
module grdfs_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic [grdfs_pkg::CMD_W-1:0] cmd,
  input logic done,
  input logic reachable,
  input logic status
);

  // An out-of-range result never claims reachability.
  a_err_not_reach: assert property (@(posedge clk) disable iff (rst)
    done |-> !(status && reachable))
    else $error("result flags both reachable and out of range");

  // Results never come in consecutive cycles.
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result beats in a row");

  // Every result ends a busy period.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without preceding work");

  // A clear produces no result.
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == grdfs_pkg::CMD_CLEAR) |=> !done ##1 !done)
    else $error("clear produced a result beat");

  // Any used command keeps the engine busy in the following cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == grdfs_pkg::CMD_CLEAR || cmd == grdfs_pkg::CMD_EDGE
     || cmd == grdfs_pkg::CMD_QUERY)) |=> busy)
    else $error("accepted command did not start work");

endmodule

bind graph_reachability_dfs grdfs_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .cmd      (cmd),
  .done     (done),
  .reachable(reachable),
  .status   (status)
);

FILE: verif/graph_reachability_dfs_tb.sv
// Self-checking testbench for the graph reachability engine: directed and random command beats.
`timescale 1ns / 1ps

module graph_reachability_dfs_tb;

  localparam logic [grdfs_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int NODES = 64;
  // Longest query walk plus some margin; used as the quiet period before a count write.
  localparam int WALK_CYCLES = 3 * NODES + 8;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic reachable;
    logic status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [grdfs_pkg::CMD_W-1:0] cmd = grdfs_pkg::CMD_CLEAR;
  logic [grdfs_pkg::NODE_W-1:0] node_a = '0;
  logic [grdfs_pkg::NODE_W-1:0] node_b = '0;
  logic cfg_we = 1'b0;
  logic [grdfs_pkg::CNT_W-1:0] cfg_wdata = '0;
  logic done;
  logic reachable;
  logic status;

  // Shadow copy of the graph and the node count.
  logic [NODES-1:0] adj_rows [NODES];
  int unsigned node_count = 64;

  verdict_t pending_verdicts[$];
  int unsigned sender_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned queries = 0;
  int unsigned hits = 0;
  int unsigned rejects = 0;

  graph_reachability_dfs i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .node_a(node_a),
    .node_b(node_b),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .reachable(reachable),
    .status(status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, pending_verdicts.size());
      $display("** graph_reachability_dfs: FAILED **");
      $finish;
    end
  end

  task automatic flag_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic enqueue_verdict(input verdict_t v);
    pending_verdicts = {pending_verdicts, v};
  endtask

  // Depth-first walk: always follows the lowest-numbered unvisited successor of the
  // node on top of the path, backing up when there is none.
  function automatic logic walk_reaches(input logic [5:0] src, input logic [5:0] dst,
                                        input int unsigned span);
    logic [NODES-1:0] live;
    logic [NODES-1:0] seen;
    logic [NODES-1:0] cand;
    logic [5:0] path [NODES];
    logic [5:0] here;
    logic [5:0] nxt;
    int unsigned depth;
    live = (span >= NODES) ? '1 : ((64'd1 << span) - 64'd1);
    seen = 64'd1 << src;
    path[0] = src;
    depth = 1;
    here = src;
    while (depth > 0) begin
      cand = adj_rows[here] & live & ~seen;
      if (cand != '0) begin
        nxt = '0;
        for (int i = NODES - 1; i >= 0; i--) if (cand[i]) nxt = i[5:0];
        seen[nxt] = 1'b1;
        if (depth < NODES) begin
          path[depth] = nxt;
          depth++;
        end
        here = nxt;
      end else begin
        depth--;
        if (depth > 0) here = path[depth-1];
      end
    end
    return seen[dst];
  endfunction

  task automatic predict_item(input logic [grdfs_pkg::CMD_W-1:0] op, input logic [5:0] a,
                              input logic [5:0] b);
    int unsigned span;
    logic fits;
    verdict_t v;
    span = (node_count > NODES) ? NODES : node_count;
    fits = (a < span) && (b < span);
    v = '0;
    case (op)
      grdfs_pkg::CMD_CLEAR: foreach (adj_rows[r]) adj_rows[r] = '0;
      grdfs_pkg::CMD_EDGE: begin
        if (fits) begin
          adj_rows[a][b] = 1'b1;
        end else begin
          v.status = 1'b1;
          rejects++;
          enqueue_verdict(v);
        end
      end
      grdfs_pkg::CMD_QUERY: begin
        queries++;
        if (fits) begin
          v.reachable = walk_reaches(a, b, span);
          if (v.reachable) hits++;
        end else begin
          v.status = 1'b1;
          rejects++;
        end
        enqueue_verdict(v);
      end
      default: ;
    endcase
  endtask

  // Sends one command beat; start stays high afterwards so that back-to-back beats
  // need no extra edge.
  task automatic send_item(input logic [grdfs_pkg::CMD_W-1:0] op, input logic [5:0] a,
                           input logic [5:0] b);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    node_a <= a;
    node_b <= b;
    do @(posedge clk); while (busy);
    beats_sent++;
    predict_item(op, a, b);
  endtask

  // Waits until every expected result has come and the engine has had time to finish
  // any command that produces none.
  task automatic settle_block();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (WALK_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [grdfs_pkg::CNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count = value;
  endtask

  function automatic logic [5:0] any_node(input int unsigned span, input int unsigned in_pct);
    if (span > 0 && $urandom_range(99) < in_pct) return 6'($urandom_range(span - 1, 0));
    return 6'($urandom_range(63, 0));
  endfunction

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && done === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        flag_fault($sformatf("Unexpected result: reachable %b status %b",
                             reachable, status));
      end else begin
        want = pending_verdicts.pop_front();
        if (reachable !== want.reachable || status !== want.status)
          flag_fault($sformatf("Result mismatch: expected reachable %b status %b, got %b %b",
                               want.reachable, want.status, reachable, status));
      end
    end
  end

  task automatic test_directed();
    sender_idle_pct = 0;
    send_item(grdfs_pkg::CMD_QUERY, 6'd0, 6'd0);
    send_item(grdfs_pkg::CMD_QUERY, 6'd63, 6'd63);
    send_item(grdfs_pkg::CMD_EDGE, 6'd0, 6'd63);
    send_item(grdfs_pkg::CMD_QUERY, 6'd0, 6'd63);
    send_item(grdfs_pkg::CMD_QUERY, 6'd63, 6'd0);
    send_item(grdfs_pkg::CMD_EDGE, 6'd63, 6'd5);
    send_item(grdfs_pkg::CMD_EDGE, 6'd5, 6'd0);
    send_item(grdfs_pkg::CMD_QUERY, 6'd63, 6'd0);
    send_item(grdfs_pkg::CMD_QUERY, 6'd5, 6'd63);
    send_item(grdfs_pkg::CMD_EDGE, 6'd7, 6'd7);
    send_item(grdfs_pkg::CMD_QUERY, 6'd7, 6'd7);
    send_item(grdfs_pkg::CMD_QUERY, 6'd7, 6'd0);
    // The spare command code must be swallowed without a result.
    send_item(CMD_SPARE, 6'd63, 6'd63);
    send_item(CMD_SPARE, 6'd0, 6'd0);
    send_item(grdfs_pkg::CMD_EDGE, 6'd5, 6'd42);
    send_item(grdfs_pkg::CMD_EDGE, 6'd5, 6'd9);
    send_item(grdfs_pkg::CMD_QUERY, 6'd63, 6'd9);
    send_item(grdfs_pkg::CMD_CLEAR, 6'd63, 6'd63);
    send_item(grdfs_pkg::CMD_QUERY, 6'd0, 6'd63);
    send_item(grdfs_pkg::CMD_QUERY, 6'd63, 6'd5);
    settle_block();
  endtask

  task automatic test_count_limits();
    // A count of zero puts every node out of range.
    write_node_count(7'd0);
    send_item(grdfs_pkg::CMD_EDGE, 6'd0, 6'd0);
    send_item(grdfs_pkg::CMD_QUERY, 6'd0, 6'd0);
    send_item(grdfs_pkg::CMD_CLEAR, 6'd0, 6'd0);
    send_item(grdfs_pkg::CMD_QUERY, 6'd63, 6'd63);
    settle_block();
    // Counts above the node limit saturate.
    write_node_count(7'd127);
    send_item(grdfs_pkg::CMD_QUERY, 6'd63, 6'd63);
    send_item(grdfs_pkg::CMD_EDGE, 6'd63, 6'd62);
    send_item(grdfs_pkg::CMD_QUERY, 6'd63, 6'd62);
    settle_block();
    write_node_count(7'd1);
    send_item(grdfs_pkg::CMD_QUERY, 6'd0, 6'd0);
    send_item(grdfs_pkg::CMD_EDGE, 6'd0, 6'd1);
    send_item(grdfs_pkg::CMD_QUERY, 6'd1, 6'd0);
    send_item(grdfs_pkg::CMD_EDGE, 6'd0, 6'd0);
    send_item(grdfs_pkg::CMD_QUERY, 6'd0, 6'd0);
    settle_block();
    // Edges through a high node stay stored but are not followed once the count shrinks.
    write_node_count(7'd64);
    send_item(grdfs_pkg::CMD_CLEAR, 6'd0, 6'd0);
    send_item(grdfs_pkg::CMD_EDGE, 6'd1, 6'd40);
    send_item(grdfs_pkg::CMD_EDGE, 6'd40, 6'd2);
    send_item(grdfs_pkg::CMD_EDGE, 6'd1, 6'd3);
    settle_block();
    write_node_count(7'd8);
    send_item(grdfs_pkg::CMD_QUERY, 6'd1, 6'd2);
    send_item(grdfs_pkg::CMD_QUERY, 6'd1, 6'd3);
    send_item(grdfs_pkg::CMD_QUERY, 6'd1, 6'd40);
    settle_block();
    write_node_count(7'd65);
    send_item(grdfs_pkg::CMD_QUERY, 6'd1, 6'd2);
    settle_block();
  endtask

  // One path through all nodes in shuffled order, plus random extra edges, can drive the walk to its full depth.
  task automatic test_deep_chain();
    logic [5:0] order [NODES];
    logic [5:0] tmp;
    int unsigned j;
    sender_idle_pct = 0;
    for (int i = 0; i < NODES; i++) order[i] = i[5:0];
    for (int i = NODES - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    write_node_count(7'd64);
    send_item(grdfs_pkg::CMD_CLEAR, 6'd0, 6'd0);
    for (int i = 0; i < NODES - 1; i++) send_item(grdfs_pkg::CMD_EDGE, order[i], order[i+1]);
    for (int i = 0; i < 5; i++)
      send_item(grdfs_pkg::CMD_EDGE, any_node(64, 100), any_node(64, 100));
    send_item(grdfs_pkg::CMD_QUERY, order[0], order[NODES-1]);
    send_item(grdfs_pkg::CMD_QUERY, order[NODES-1], order[0]);
    for (int i = 0; i < 6; i++)
      send_item(grdfs_pkg::CMD_QUERY, any_node(64, 100), any_node(64, 100));
    settle_block();
  endtask

  // Rounds of: new count, optional clear, a random edge set with occasional spare commands, then queries over it.
  task automatic test_random_graphs(input int unsigned items, input int unsigned idle_pct);
    int unsigned sent;
    int unsigned span;
    int unsigned edges;
    int unsigned asks;
    logic [grdfs_pkg::CNT_W-1:0] count_val;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0: count_val = 7'd64;
        1: count_val = 7'($urandom_range(127, 65));
        2: count_val = 7'($urandom_range(63, 17));
        default: count_val = 7'($urandom_range(16, 2));
      endcase
      write_node_count(count_val);
      span = (count_val > NODES) ? NODES : count_val;
      if ($urandom_range(3) != 0) begin
        send_item(grdfs_pkg::CMD_CLEAR, any_node(64, 0), any_node(64, 0));
        sent++;
      end
      edges = $urandom_range((span > 16) ? 40 : 2 * span, 1);
      for (int i = 0; i < edges; i++) begin
        if ($urandom_range(19) == 0)
          send_item(CMD_SPARE, any_node(64, 0), any_node(64, 0));
        send_item(grdfs_pkg::CMD_EDGE, any_node(span, 92), any_node(span, 92));
        sent++;
      end
      asks = $urandom_range(12, 4);
      for (int i = 0; i < asks; i++) begin
        send_item(grdfs_pkg::CMD_QUERY, any_node(span, 90), any_node(span, 90));
        sent++;
      end
      settle_block();
    end
  endtask

  initial begin
    foreach (adj_rows[r]) adj_rows[r] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_count_limits();
    test_deep_chain();
    test_random_graphs(200, 0);
    test_random_graphs(200, 53);
    test_random_graphs(200, 32);
    settle_block();
    if (pending_verdicts.size() != 0)
      flag_fault($sformatf("%0d expected results never arrived", pending_verdicts.size()));
    $display("Sent %0d command beats over node counts 0 to 127: %0d queries, %0d reachable,",
             beats_sent, queries, hits);
    $display("%0d rejected for range; %0d mismatches in %0d cycles.",
             rejects, mismatches, cycles);
    if (mismatches == 0) begin
      $display("** graph_reachability_dfs: PASSED **");
    end else begin
      $display("** graph_reachability_dfs: FAILED **");
    end
    $finish;
  end

endmodule
